// ===== rtl/core/ray_cylinder_intersect_top_defines.svh =====
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef RAY_CYLINDER_INTERSECT_TOP_DEFINES_SVH
`define RAY_CYLINDER_INTERSECT_TOP_DEFINES_SVH

// same-cycle implication
`define RCI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rci_pkg.sv =====
`timescale 1ns / 1ps

package rci_pkg;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vec_t;

  typedef struct packed {
    q_t origin_x;
    q_t origin_y;
    q_t origin_z;
    q_t direction_x;
    q_t direction_y;
    q_t direction_z;
  } ray_word_t;

  typedef struct packed {
    logic [2:0] hit_kind;
    q_t         hit_t;
    q_t         hit_x;
    q_t         hit_y;
    q_t         hit_z;
    q_t         normal_x;
    q_t         normal_y;
    q_t         normal_z;
    logic       last_hit;
  } hit_word_t;

  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_CENTER_Z    = 3'd2,
    CFG_AXIS_X      = 3'd3,
    CFG_AXIS_Y      = 3'd4,
    CFG_AXIS_Z      = 3'd5,
    CFG_HALF_HEIGHT = 3'd6,
    CFG_RADIUS      = 3'd7
  } cfg_idx_e;

  localparam logic [2:0] KIND_MISS   = 3'd0;
  localparam logic [2:0] KIND_TOP    = 3'd1;
  localparam logic [2:0] KIND_BOTTOM = 3'd2;
  localparam logic [2:0] KIND_FAR    = 3'd3;
  localparam logic [2:0] KIND_NEAR   = 3'd4;

  // register stages inside the divider and the square root units
  localparam int unsigned DIV_LAT  = 33;
  localparam int unsigned SQRT_LAT = 25;

  localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] QMIN64 = -64'sd2147483648;
  localparam q_t QMAX = 32'sh7fffffff;
  localparam q_t QMIN = 32'sh80000000;

  function automatic q_t sat(input logic signed [63:0] v);
    q_t r;
    if (v > QMAX64) begin
      r = QMAX;
    end else if (v < QMIN64) begin
      r = QMIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = a;
    eb = b;
    return sat(ea + eb);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = a;
    eb = b;
    return sat(ea - eb);
  endfunction

  // floor of the product in Q16.16
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    logic signed [63:0] p;
    ea = a;
    eb = b;
    p  = ea * eb;
    return sat(p >>> 16);
  endfunction

  function automatic q_t sat2(input q_t a);
    logic signed [63:0] ea;
    ea = a;
    return sat(ea <<< 1);
  endfunction

  function automatic q_t sat4(input q_t a);
    logic signed [63:0] ea;
    ea = a;
    return sat(ea <<< 2);
  endfunction

  function automatic vec_t vadd(input vec_t a, input vec_t b);
    vec_t r;
    r.x = qadd(a.x, b.x);
    r.y = qadd(a.y, b.y);
    r.z = qadd(a.z, b.z);
    return r;
  endfunction

  function automatic vec_t vsub(input vec_t a, input vec_t b);
    vec_t r;
    r.x = qsub(a.x, b.x);
    r.y = qsub(a.y, b.y);
    r.z = qsub(a.z, b.z);
    return r;
  endfunction

  function automatic vec_t vmul(input vec_t a, input vec_t b);
    vec_t r;
    r.x = qmul(a.x, b.x);
    r.y = qmul(a.y, b.y);
    r.z = qmul(a.z, b.z);
    return r;
  endfunction

  function automatic vec_t vscale(input q_t s, input vec_t a);
    vec_t r;
    r.x = qmul(s, a.x);
    r.y = qmul(s, a.y);
    r.z = qmul(s, a.z);
    return r;
  endfunction

  // dot product tail: left to right saturating sum of the products
  function automatic q_t vsum(input vec_t a);
    return qadd(qadd(a.x, a.y), a.z);
  endfunction

endpackage

// ===== rtl/core/rci_div.sv =====
`timescale 1ns / 1ps

module rci_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  rci_pkg::q_t   num_i,
  input  rci_pkg::q_t   den_i,
  output rci_pkg::q_t   quo_o
);
  import rci_pkg::*;

  localparam int unsigned STEPS = DIV_LAT - 1;

  logic [31:0] an;
  logic [31:0] bn;

  logic [31:0] rem_q [0:STEPS];
  logic [31:0] low_q [0:STEPS];
  logic [31:0] quo_q [0:STEPS];
  logic [31:0] bn_q  [0:STEPS];
  logic [STEPS:0] neg_q;
  logic [STEPS:0] ovf_q;

  logic [32:0] tr_c  [1:STEPS];
  logic [31:0] rem_d [1:STEPS];
  logic [31:0] quo_d [1:STEPS];
  logic [31:0] mag;

  always_comb begin
    an = num_i[31] ? (~num_i + 32'd1) : num_i;
    bn = den_i[31] ? (~den_i + 32'd1) : den_i;
    for (int k = 1; k <= STEPS; k++) begin
      tr_c[k] = {rem_q[k-1], low_q[k-1][31]};
      if (tr_c[k] >= {1'b0, bn_q[k-1]}) begin
        rem_d[k] = 32'(tr_c[k] - {1'b0, bn_q[k-1]});
        quo_d[k] = {quo_q[k-1][30:0], 1'b1};
      end else begin
        rem_d[k] = tr_c[k][31:0];
        quo_d[k] = {quo_q[k-1][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {16'b0, an[31:16]};
      low_q[0] <= {an[15:0], 16'b0};
      quo_q[0] <= '0;
      bn_q[0]  <= bn;
      neg_q[0] <= num_i[31] ^ den_i[31];
      ovf_q[0] <= {16'b0, an[31:16]} >= bn;
      for (int k = 1; k <= STEPS; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= {low_q[k-1][30:0], 1'b0};
        quo_q[k] <= quo_d[k];
        bn_q[k]  <= bn_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign mag = quo_q[STEPS];

  always_comb begin
    if (ovf_q[STEPS]) begin
      quo_o = neg_q[STEPS] ? QMIN : QMAX;
    end else if (!neg_q[STEPS]) begin
      quo_o = mag[31] ? QMAX : mag;
    end else begin
      quo_o = (mag > 32'h80000000) ? QMIN : (~mag + 32'd1);
    end
  end

endmodule

// ===== rtl/core/rci_sqrt.sv =====
`timescale 1ns / 1ps

module rci_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] rad_i,
  output logic [23:0] root_o
);
  import rci_pkg::*;

  localparam int unsigned STEPS = SQRT_LAT - 1;

  logic [47:0] v_q [0:STEPS];
  logic [47:0] r_q [0:STEPS];
  logic [47:0] bit_c [1:STEPS];
  logic [47:0] sum_c [1:STEPS];
  logic [47:0] v_d [1:STEPS];
  logic [47:0] r_d [1:STEPS];

  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      bit_c[k] = 48'd1 << (2 * (STEPS - k));
      sum_c[k] = r_q[k-1] + bit_c[k];
      if (v_q[k-1] >= sum_c[k]) begin
        v_d[k] = v_q[k-1] - sum_c[k];
        r_d[k] = (r_q[k-1] >> 1) + bit_c[k];
      end else begin
        v_d[k] = v_q[k-1];
        r_d[k] = r_q[k-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= {1'b0, rad_i, 16'b0};
      r_q[0] <= '0;
      for (int k = 1; k <= STEPS; k++) begin
        v_q[k] <= v_d[k];
        r_q[k] <= r_d[k];
      end
    end
  end

  assign root_o = r_q[STEPS][23:0];

endmodule

// ===== rtl/core/ray_cylinder_intersect_top.sv =====
`timescale 1ns / 1ps
// ray against capped cylinder, signed Q16.16
// input channel: one ray word (origin, direction) per in_valid_i / in_stall_o handshake
// output channel: hit words in order top cap, bottom cap, far side, near side, or
//   one miss word; last_hit marks the final word of a ray
// config port: cfg_we_i writes cfg_data_i into the register named by cfg_idx_i;
//   write only while no ray is in flight
// pipe: the first word of a ray leaves the emit stage through a registered output
//   (a 79 stage pipe; the side path runs a 25 stage square root, then a 33 stage divider)
// throughput: one ray per cycle when each ray yields one word and out_stall_i is low;
//   a ray with more hit words holds the pipe at the emit stage until its last word is sent
// reset: pipe and output are emptied, registers return to their defaults
//   (center 0, axis +y, half height and radius 0.5)
// a stalled output holds its word; the whole pipe freezes while the emit stage
//   waits, and in_stall_o rises so nothing is lost or repeated
`include "ray_cylinder_intersect_top_defines.svh"

module ray_cylinder_intersect_top #(
  parameter int unsigned SIDE_TOLERANCE = 66
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rci_pkg::ray_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rci_pkg::hit_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import rci_pkg::*;

  localparam q_t TOL  = 32'(SIDE_TOLERANCE);
  localparam q_t NTOL = -TOL;

  // config
  vec_t               cen_q;
  logic signed [17:0] ax_q, ay_q, az_q;
  logic [30:0]        hh_q, rad_q;
  vec_t               nv, nneg;
  q_t                 h32, r32;
  vec_t               hn_q, ctop_q, cbot_q;
  q_t                 rr_q;

  // pipeline
  logic [78:0] v_q;
  logic        adv;

  vec_t o_q [0:71];
  vec_t d_q [0:70];
  vec_t f_q [1:4];
  vec_t pdn_q, pfn_q, ut_q, ub_q, pa_q, put_q, pub_q, pbn_q, be_q;
  q_t   dn_q [2:4];
  q_t   fn_q, numt_q, numb_q;
  vec_t al_q [4:5];
  logic [47:4] capok_q;
  vec_t paa_q, pab_q, pbb_q;
  q_t   qa_q [7:9];
  q_t   qb_q [7:9];
  q_t   bbs_q, qc_q, ac_q, disc_q, disc_d;
  q_t   bsq_q [8:9];
  q_t   den_q [10:36];
  logic signed [32:0] negb_q [10:35];
  logic [75:10] sok_q;
  logic [23:0] root;
  q_t   num0_q, num1_q;
  logic signed [63:0] nb_e, rt_e;

  q_t   tt_div, tb_div, t0_div, t1_div;
  q_t   tt_q [38:78];
  q_t   tb_q [38:78];
  vec_t mt_q, mb_q;
  vec_t pt_q [40:78];
  vec_t pb_q [40:78];
  vec_t gvt_q [41:44];
  vec_t gvb_q [41:44];
  vec_t gnt_q, gnb_q, kt_q, kb_q, gt_q, gb_q, sqt_q, sqb_q;
  q_t   st_q, sb_q, sst_q, ssb_q;
  logic [78:48] okt_q, okb_q;

  q_t   ts0_q [70:78];
  q_t   ts1_q [70:78];
  vec_t m0_q, m1_q;
  vec_t q0_q [72:78];
  vec_t q1_q [72:78];
  vec_t e0t_q, e0b_q, e0c_q, e1t_q, e1b_q, e1c_q;
  vec_t p0t_q, p0b_q, p0c_q, p1t_q, p1b_q, p1c_q;
  q_t   s0t_q, s0b_q, s0c_q, s1t_q, s1b_q, s1c_q;
  logic [78:76] keep0_q, keep1_q;
  vec_t kk0_q, kk1_q, mm0_q, mm1_q, nm0_q, nm1_q;

  // emit
  logic [3:0]  hits;
  logic [4:0]  want, pend, pick, sent_q;
  logic        last, out_free, fire;
  hit_word_t   rec, out_q;
  logic        out_v_q;

  always_comb begin
    nv.x   = 32'(ax_q);
    nv.y   = 32'(ay_q);
    nv.z   = 32'(az_q);
    nneg   = vsub('0, nv);
    h32    = {1'b0, hh_q};
    r32    = {1'b0, rad_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q  <= '0;
      ax_q   <= '0;
      ay_q   <= 18'sd65536;
      az_q   <= '0;
      hh_q   <= 31'd32768;
      rad_q  <= 31'd32768;
      hn_q   <= '{x: 32'sd0, y: 32'sd32768, z: 32'sd0};
      ctop_q <= '{x: 32'sd0, y: 32'sd32768, z: 32'sd0};
      cbot_q <= '{x: 32'sd0, y: -32'sd32768, z: 32'sd0};
      rr_q   <= 32'sd16384;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CENTER_X:    cen_q.x <= cfg_data_i;
          CFG_CENTER_Y:    cen_q.y <= cfg_data_i;
          CFG_CENTER_Z:    cen_q.z <= cfg_data_i;
          CFG_AXIS_X:      ax_q    <= cfg_data_i[17:0];
          CFG_AXIS_Y:      ay_q    <= cfg_data_i[17:0];
          CFG_AXIS_Z:      az_q    <= cfg_data_i[17:0];
          CFG_HALF_HEIGHT: hh_q    <= cfg_data_i[30:0];
          CFG_RADIUS:      rad_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      hn_q   <= vscale(h32, nv);
      ctop_q <= vadd(cen_q, hn_q);
      cbot_q <= vsub(cen_q, hn_q);
      rr_q   <= qmul(r32, r32);
    end
  end

  // dividers and square root
  rci_div u_div_top (.clk_i, .en_i(adv), .num_i(numt_q), .den_i(dn_q[4]), .quo_o(tt_div));
  rci_div u_div_bot (.clk_i, .en_i(adv), .num_i(numb_q), .den_i(dn_q[4]), .quo_o(tb_div));
  rci_sqrt u_sqrt (.clk_i, .en_i(adv), .rad_i(disc_q[30:0]), .root_o(root));
  rci_div u_div_far (.clk_i, .en_i(adv), .num_i(num0_q), .den_i(den_q[36]), .quo_o(t0_div));
  rci_div u_div_near (.clk_i, .en_i(adv), .num_i(num1_q), .den_i(den_q[36]), .quo_o(t1_div));

  assign disc_d = qsub(bsq_q[9], sat4(ac_q));
  assign nb_e   = 64'(negb_q[35]);
  assign rt_e   = {40'b0, root};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[77:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // carried operands
      o_q[0] <= '{x: in_word_i.origin_x, y: in_word_i.origin_y, z: in_word_i.origin_z};
      d_q[0] <= '{x: in_word_i.direction_x, y: in_word_i.direction_y,
                  z: in_word_i.direction_z};
      for (int k = 1; k <= 71; k++) o_q[k] <= o_q[k-1];
      for (int k = 1; k <= 70; k++) d_q[k] <= d_q[k-1];
      for (int k = 2; k <= 4; k++) f_q[k] <= f_q[k-1];

      // axial terms
      pdn_q   <= vmul(d_q[0], nv);
      f_q[1]  <= vsub(o_q[0], cen_q);
      dn_q[2] <= vsum(pdn_q);
      dn_q[3] <= dn_q[2];
      dn_q[4] <= dn_q[3];
      pfn_q   <= vmul(f_q[1], nv);
      ut_q    <= vsub(ctop_q, o_q[1]);
      ub_q    <= vsub(cbot_q, o_q[1]);
      fn_q    <= vsum(pfn_q);
      pa_q    <= vscale(dn_q[2], nv);
      put_q   <= vmul(ut_q, nv);
      pub_q   <= vmul(ub_q, nv);
      numt_q  <= vsum(put_q);
      numb_q  <= vsum(pub_q);
      al_q[4] <= vsub(d_q[3], pa_q);
      al_q[5] <= al_q[4];
      pbn_q   <= vscale(fn_q, nv);
      capok_q <= {capok_q[46:4], dn_q[3] != 32'sd0};
      be_q    <= vsub(f_q[4], pbn_q);

      // quadratic coefficients
      paa_q   <= vmul(al_q[5], al_q[5]);
      pab_q   <= vmul(al_q[5], be_q);
      pbb_q   <= vmul(be_q, be_q);
      qa_q[7] <= vsum(paa_q);
      qb_q[7] <= sat2(vsum(pab_q));
      bbs_q   <= vsum(pbb_q);
      qa_q[8] <= qa_q[7];
      qb_q[8] <= qb_q[7];
      qa_q[9] <= qa_q[8];
      qb_q[9] <= qb_q[8];
      qc_q    <= qsub(bbs_q, rr_q);
      bsq_q[8] <= qmul(qb_q[7], qb_q[7]);
      bsq_q[9] <= bsq_q[8];
      ac_q    <= qmul(qa_q[8], qc_q);
      disc_q  <= disc_d;
      den_q[10]  <= sat2(qa_q[9]);
      negb_q[10] <= -{qb_q[9][31], qb_q[9]};
      for (int k = 11; k <= 36; k++) den_q[k] <= den_q[k-1];
      for (int k = 11; k <= 35; k++) negb_q[k] <= negb_q[k-1];
      sok_q   <= {sok_q[74:10], (qa_q[9] != 32'sd0) && !disc_d[31]};
      num0_q  <= sat(nb_e + rt_e);
      num1_q  <= sat(nb_e - rt_e);

      // cap hits
      tt_q[38] <= tt_div;
      tb_q[38] <= tb_div;
      for (int k = 39; k <= 78; k++) begin
        tt_q[k] <= tt_q[k-1];
        tb_q[k] <= tb_q[k-1];
      end
      mt_q <= vscale(tt_q[38], d_q[38]);
      mb_q <= vscale(tb_q[38], d_q[38]);
      pt_q[40] <= vadd(o_q[39], mt_q);
      pb_q[40] <= vadd(o_q[39], mb_q);
      for (int k = 41; k <= 78; k++) begin
        pt_q[k] <= pt_q[k-1];
        pb_q[k] <= pb_q[k-1];
      end
      gvt_q[41] <= vsub(pt_q[40], cen_q);
      gvb_q[41] <= vsub(pb_q[40], cen_q);
      for (int k = 42; k <= 44; k++) begin
        gvt_q[k] <= gvt_q[k-1];
        gvb_q[k] <= gvb_q[k-1];
      end
      gnt_q <= vmul(gvt_q[41], nv);
      gnb_q <= vmul(gvb_q[41], nv);
      st_q  <= vsum(gnt_q);
      sb_q  <= vsum(gnb_q);
      kt_q  <= vscale(st_q, nv);
      kb_q  <= vscale(sb_q, nv);
      gt_q  <= vsub(gvt_q[44], kt_q);
      gb_q  <= vsub(gvb_q[44], kb_q);
      sqt_q <= vmul(gt_q, gt_q);
      sqb_q <= vmul(gb_q, gb_q);
      sst_q <= vsum(sqt_q);
      ssb_q <= vsum(sqb_q);
      okt_q <= {okt_q[77:48], capok_q[47] && (qsub(sst_q, rr_q) <= 32'sd0)};
      okb_q <= {okb_q[77:48], capok_q[47] && (qsub(ssb_q, rr_q) <= 32'sd0)};

      // side hits
      ts0_q[70] <= t0_div;
      ts1_q[70] <= t1_div;
      for (int k = 71; k <= 78; k++) begin
        ts0_q[k] <= ts0_q[k-1];
        ts1_q[k] <= ts1_q[k-1];
      end
      m0_q <= vscale(ts0_q[70], d_q[70]);
      m1_q <= vscale(ts1_q[70], d_q[70]);
      q0_q[72] <= vadd(o_q[71], m0_q);
      q1_q[72] <= vadd(o_q[71], m1_q);
      for (int k = 73; k <= 78; k++) begin
        q0_q[k] <= q0_q[k-1];
        q1_q[k] <= q1_q[k-1];
      end
      e0t_q <= vsub(q0_q[72], ctop_q);
      e0b_q <= vsub(q0_q[72], cbot_q);
      e0c_q <= vsub(q0_q[72], cen_q);
      e1t_q <= vsub(q1_q[72], ctop_q);
      e1b_q <= vsub(q1_q[72], cbot_q);
      e1c_q <= vsub(q1_q[72], cen_q);
      p0t_q <= vmul(e0t_q, nv);
      p0b_q <= vmul(e0b_q, nv);
      p0c_q <= vmul(e0c_q, nv);
      p1t_q <= vmul(e1t_q, nv);
      p1b_q <= vmul(e1b_q, nv);
      p1c_q <= vmul(e1c_q, nv);
      s0t_q <= vsum(p0t_q);
      s0b_q <= vsum(p0b_q);
      s0c_q <= vsum(p0c_q);
      s1t_q <= vsum(p1t_q);
      s1b_q <= vsum(p1b_q);
      s1c_q <= vsum(p1c_q);
      keep0_q <= {keep0_q[77:76], sok_q[75] && (s0t_q < NTOL) && (s0b_q > TOL)};
      keep1_q <= {keep1_q[77:76], sok_q[75] && (s1t_q < NTOL) && (s1b_q > TOL)};
      kk0_q <= vscale(s0c_q, nv);
      kk1_q <= vscale(s1c_q, nv);
      mm0_q <= vadd(cen_q, kk0_q);
      mm1_q <= vadd(cen_q, kk1_q);
      nm0_q <= vsub(q0_q[77], mm0_q);
      nm1_q <= vsub(q1_q[77], mm1_q);
    end
  end

  // emit stage: one word per hit of the ray in the last bank, or one miss word if none
  always_comb begin
    hits     = {keep1_q[78], keep0_q[78], okb_q[78], okt_q[78]};
    want     = (hits == 4'b0) ? 5'b10000 : {1'b0, hits};
    pend     = want & ~sent_q;
    pick     = pend & (~pend + 5'd1);
    last     = (pend & ~pick) == 5'b0;
    out_free = !out_v_q || !out_stall_i;
    fire     = v_q[78] && out_free;
    adv      = !v_q[78] || (fire && last);
  end

  always_comb begin
    rec          = '0;
    rec.last_hit = last;
    if (pick[0]) begin
      rec.hit_kind = KIND_TOP;
      rec.hit_t    = tt_q[78];
      rec.hit_x    = pt_q[78].x;
      rec.hit_y    = pt_q[78].y;
      rec.hit_z    = pt_q[78].z;
      rec.normal_x = nv.x;
      rec.normal_y = nv.y;
      rec.normal_z = nv.z;
    end else if (pick[1]) begin
      rec.hit_kind = KIND_BOTTOM;
      rec.hit_t    = tb_q[78];
      rec.hit_x    = pb_q[78].x;
      rec.hit_y    = pb_q[78].y;
      rec.hit_z    = pb_q[78].z;
      rec.normal_x = nneg.x;
      rec.normal_y = nneg.y;
      rec.normal_z = nneg.z;
    end else if (pick[2]) begin
      rec.hit_kind = KIND_FAR;
      rec.hit_t    = ts0_q[78];
      rec.hit_x    = q0_q[78].x;
      rec.hit_y    = q0_q[78].y;
      rec.hit_z    = q0_q[78].z;
      rec.normal_x = nm0_q.x;
      rec.normal_y = nm0_q.y;
      rec.normal_z = nm0_q.z;
    end else if (pick[3]) begin
      rec.hit_kind = KIND_NEAR;
      rec.hit_t    = ts1_q[78];
      rec.hit_x    = q1_q[78].x;
      rec.hit_y    = q1_q[78].y;
      rec.hit_z    = q1_q[78].z;
      rec.normal_x = nm1_q.x;
      rec.normal_y = nm1_q.y;
      rec.normal_z = nm1_q.z;
    end else begin
      rec.hit_kind = KIND_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sent_q  <= '0;
    end else if (fire) begin
      out_v_q <= 1'b1;
      sent_q  <= last ? 5'b0 : (sent_q | pick);
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rec;
    end
  end

  assign in_stall_o  = !adv;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  `RCI_ASSERT_NXT(a_hold_last_bank, v_q[78] && !adv, v_q[78], "emit stage lost its ray")
  `RCI_ASSERT_IMP(a_empty_no_stall, !v_q[78], !in_stall_o, "stall with empty emit stage")
  `RCI_ASSERT_IMP(a_last_frees, fire && last, adv, "final word did not release pipe")
  `RCI_ASSERT_IMP(a_sent_clear, !v_q[78], sent_q == 5'b0, "sent mask left over")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rci_pkg::*;

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam int SIDE_TOL = 66;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } fx_vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ray_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hit_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [31:0] cyl_regs [8];
  hit_word_t hit_words_q [$];
  int fail_cnt = 0;
  int ray_cnt = 0;
  int hit_cnt = 0;
  int kind_seen [5];
  int cycle_cnt = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  ray_cylinder_intersect_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // fixed point helpers
  function automatic longint clamp(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clamp((a * b) >>> 16);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    return clamp((a * 65536) / b);
  endfunction

  function automatic longint fx_sqrt(longint x);
    longint unsigned v, r, bit_v;
    v = longint'(x) << 16;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return longint'(r);
  endfunction

  function automatic fx_vec_t v_add(fx_vec_t a, fx_vec_t b);
    fx_vec_t r;
    r.x = clamp(a.x + b.x);
    r.y = clamp(a.y + b.y);
    r.z = clamp(a.z + b.z);
    return r;
  endfunction

  function automatic fx_vec_t v_sub(fx_vec_t a, fx_vec_t b);
    fx_vec_t r;
    r.x = clamp(a.x - b.x);
    r.y = clamp(a.y - b.y);
    r.z = clamp(a.z - b.z);
    return r;
  endfunction

  function automatic fx_vec_t v_scale(longint s, fx_vec_t a);
    fx_vec_t r;
    r.x = fx_mul(s, a.x);
    r.y = fx_mul(s, a.y);
    r.z = fx_mul(s, a.z);
    return r;
  endfunction

  function automatic longint v_dot(fx_vec_t a, fx_vec_t b);
    return clamp(clamp(fx_mul(a.x, b.x) + fx_mul(a.y, b.y)) + fx_mul(a.z, b.z));
  endfunction

  function automatic fx_vec_t off_axis(fx_vec_t f, fx_vec_t n);
    return v_sub(f, v_scale(v_dot(f, n), n));
  endfunction

  function automatic hit_word_t make_hit(logic [2:0] kind, longint t, fx_vec_t p,
                                         fx_vec_t nn);
    hit_word_t h;
    h.hit_kind = kind;
    h.hit_t = t[31:0];
    h.hit_x = p.x[31:0];
    h.hit_y = p.y[31:0];
    h.hit_z = p.z[31:0];
    h.normal_x = nn.x[31:0];
    h.normal_y = nn.y[31:0];
    h.normal_z = nn.z[31:0];
    h.last_hit = 1'b0;
    return h;
  endfunction

  task automatic predict_hits(ray_word_t w);
    fx_vec_t c, n, nneg, o, d, hn, ctop, cbot, pt, pb, gt, gb, al, be, q, nm, z;
    longint h, r, rr, dn, tt, tb, a_q, b_q, c_q, disc, s, den, top, bot;
    longint ts [2];
    hit_word_t found [$];
    c = '{longint'($signed(cyl_regs[CFG_CENTER_X])), longint'($signed(cyl_regs[CFG_CENTER_Y])),
          longint'($signed(cyl_regs[CFG_CENTER_Z]))};
    n = '{longint'($signed(cyl_regs[CFG_AXIS_X][17:0])),
          longint'($signed(cyl_regs[CFG_AXIS_Y][17:0])),
          longint'($signed(cyl_regs[CFG_AXIS_Z][17:0]))};
    h = longint'(cyl_regs[CFG_HALF_HEIGHT][30:0]);
    r = longint'(cyl_regs[CFG_RADIUS][30:0]);
    o = '{longint'(w.origin_x), longint'(w.origin_y), longint'(w.origin_z)};
    d = '{longint'(w.direction_x), longint'(w.direction_y), longint'(w.direction_z)};
    nneg = '{-n.x, -n.y, -n.z};
    z = '{0, 0, 0};
    hn = v_scale(h, n);
    ctop = v_add(c, hn);
    cbot = v_sub(c, hn);
    rr = fx_mul(r, r);
    dn = v_dot(d, n);
    if (dn != 0) begin
      tt = fx_div(v_dot(v_sub(ctop, o), n), dn);
      tb = fx_div(v_dot(v_sub(cbot, o), n), dn);
      pt = v_add(o, v_scale(tt, d));
      pb = v_add(o, v_scale(tb, d));
      gt = off_axis(v_sub(pt, c), n);
      gb = off_axis(v_sub(pb, c), n);
      if (clamp(v_dot(gt, gt) - rr) <= 0) found = {found, make_hit(KIND_TOP, tt, pt, n)};
      if (clamp(v_dot(gb, gb) - rr) <= 0) found = {found, make_hit(KIND_BOTTOM, tb, pb, nneg)};
    end
    al = off_axis(d, n);
    be = off_axis(v_sub(o, c), n);
    a_q = v_dot(al, al);
    b_q = clamp(2 * v_dot(al, be));
    c_q = clamp(v_dot(be, be) - rr);
    disc = clamp(fx_mul(b_q, b_q) - clamp(4 * fx_mul(a_q, c_q)));
    if (a_q != 0 && disc >= 0) begin
      s = fx_sqrt(disc);
      den = clamp(2 * a_q);
      ts[0] = fx_div(clamp(-b_q + s), den);
      ts[1] = fx_div(clamp(-b_q - s), den);
      for (int i = 0; i < 2; i++) begin
        q = v_add(o, v_scale(ts[i], d));
        top = v_dot(v_sub(q, ctop), n);
        bot = v_dot(v_sub(q, cbot), n);
        if (top < -SIDE_TOL && bot > SIDE_TOL) begin
          nm = v_sub(q, v_add(c, v_scale(v_dot(v_sub(q, c), n), n)));
          found = {found, make_hit(i == 0 ? KIND_FAR : KIND_NEAR, ts[i], q, nm)};
        end
      end
    end
    if (found.size() == 0) found = {found, make_hit(KIND_MISS, 0, z, z)};
    found[found.size() - 1].last_hit = 1'b1;
    foreach (found[i]) hit_words_q = {hit_words_q, found[i]};
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls plus one long hold on request
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 400;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else begin
      stall_left = gap_len();
    end
    out_stall_i <= (stall_left > 0);
  end

  // result checker
  always @(posedge clk_i) begin
    hit_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_words_q.size() == 0) begin
        $error("unexpected hit word %p", out_word_o);
        fail_cnt++;
      end else begin
        e = hit_words_q.pop_front();
        hit_cnt++;
        if (e.hit_kind <= KIND_NEAR) kind_seen[e.hit_kind]++;
        if (out_word_o.hit_kind !== e.hit_kind) begin
          $error("hit_kind exp %0d got %0d", e.hit_kind, out_word_o.hit_kind); fail_cnt++;
        end
        if (out_word_o.hit_t !== e.hit_t) begin
          $error("hit_t exp %0d got %0d", e.hit_t, out_word_o.hit_t); fail_cnt++;
        end
        if (out_word_o.hit_x !== e.hit_x) begin
          $error("hit_x exp %0d got %0d", e.hit_x, out_word_o.hit_x); fail_cnt++;
        end
        if (out_word_o.hit_y !== e.hit_y) begin
          $error("hit_y exp %0d got %0d", e.hit_y, out_word_o.hit_y); fail_cnt++;
        end
        if (out_word_o.hit_z !== e.hit_z) begin
          $error("hit_z exp %0d got %0d", e.hit_z, out_word_o.hit_z); fail_cnt++;
        end
        if (out_word_o.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, out_word_o.normal_x); fail_cnt++;
        end
        if (out_word_o.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, out_word_o.normal_y); fail_cnt++;
        end
        if (out_word_o.normal_z !== e.normal_z) begin
          $error("normal_z exp %0d got %0d", e.normal_z, out_word_o.normal_z); fail_cnt++;
        end
        if (out_word_o.last_hit !== e.last_hit) begin
          $error("last_hit exp %0d got %0d", e.last_hit, out_word_o.last_hit); fail_cnt++;
        end
      end
    end
  end

  task automatic send_ray(ray_word_t w);
    int g;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_hits(w);
    ray_cnt++;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (hit_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cyl_regs[idx] = val;
    @(posedge clk_i);
  endtask

  function automatic ray_word_t ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                                    longint dz);
    ray_word_t w;
    w.origin_x = ox[31:0];
    w.origin_y = oy[31:0];
    w.origin_z = oz[31:0];
    w.direction_x = dx[31:0];
    w.direction_y = dy[31:0];
    w.direction_z = dz[31:0];
    return w;
  endfunction

  function automatic longint near_val(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_word_t aimed_ray();
    fx_vec_t c;
    longint sp;
    c = '{longint'($signed(cyl_regs[CFG_CENTER_X])), longint'($signed(cyl_regs[CFG_CENTER_Y])),
          longint'($signed(cyl_regs[CFG_CENTER_Z]))};
    sp = $urandom_range(0, 3) == 0 ? 64'd1000000 : 64'd200000;
    return ray(clamp(c.x + near_val(sp)), clamp(c.y + near_val(sp)), clamp(c.z + near_val(sp)),
               near_val(131072), near_val(131072), near_val(131072));
  endfunction

  function automatic ray_word_t wild_ray();
    return ray(longint'($signed($urandom())), longint'($signed($urandom())),
               longint'($signed($urandom())), longint'($signed($urandom())),
               longint'($signed($urandom())), longint'($signed($urandom())));
  endfunction

  task automatic test_directed_defaults();
    send_ray(ray(0, 131072, 0, 0, -65536, 0));
    send_ray(ray(0, -131072, 0, 0, 65536, 0));
    send_ray(ray(-131072, 0, 0, 65536, 0, 0));
    send_ray(ray(0, 0, 131072, 0, 0, -65536));
    send_ray(ray(327680, 327680, 327680, 65536, 0, 0));
    send_ray(ray(-131072, 131072, 0, 65536, -65536, 0));
    send_ray(ray(10000, 0, 0, 0, 0, 0));
    send_ray(ray(0, 0, 0, 65536, 0, 0));
    send_ray(ray(-131072, 32768, 0, 65536, 0, 0));
    send_ray(ray(-131072, 32700, 0, 65536, 0, 0));
    send_ray(ray(0, 131072, 32768, 0, -65536, 0));
    send_ray(ray(QHI, QHI, QHI, QHI, QHI, QHI));
    send_ray(ray(QLO, QLO, QLO, QLO, QLO, QLO));
    send_ray(ray(QLO, QHI, 0, QHI, QLO, 1));
    send_ray(ray(0, 0, 0, QLO, QLO, QLO));
    send_ray(ray(-1, -1, -1, -1, -1, -1));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_CENTER_X, 32'h7fffffff);
    write_reg(CFG_CENTER_Y, 32'h80000000);
    write_reg(CFG_CENTER_Z, 32'h00010000);
    write_reg(CFG_AXIS_X, 32'h0003_0000);
    write_reg(CFG_AXIS_Y, 32'h0000_0000);
    write_reg(CFG_AXIS_Z, 32'h0000_0000);
    write_reg(CFG_HALF_HEIGHT, 32'h7fffffff);
    write_reg(CFG_RADIUS, 32'h00000000);
    send_ray(ray(0, 0, 65536, 65536, 0, 0));
    send_ray(ray(QHI, QLO, 65536, 0, 65536, 0));
    send_ray(wild_ray());
    wait_idle();
    write_reg(CFG_CENTER_X, 32'h0);
    write_reg(CFG_CENTER_Y, 32'h0);
    write_reg(CFG_CENTER_Z, 32'h0);
    write_reg(CFG_AXIS_X, 32'hffff_0000);
    write_reg(CFG_HALF_HEIGHT, 32'h0);
    write_reg(CFG_RADIUS, 32'h7fffffff);
    send_ray(ray(131072, 0, 0, -65536, 0, 0));
    send_ray(ray(0, 131072, 0, 0, -65536, 0));
    send_ray(wild_ray());
    wait_idle();
  endtask

  task automatic random_phase(int n_rays);
    for (int i = 0; i < n_rays; i++) begin
      if ($urandom_range(0, 9) < 8) send_ray(aimed_ray());
      else send_ray(wild_ray());
    end
    wait_idle();
  endtask

  task automatic test_random_configs();
    write_reg(CFG_AXIS_X, 32'h0);
    write_reg(CFG_AXIS_Y, 32'h0);
    write_reg(CFG_AXIS_Z, 32'h00010000);
    write_reg(CFG_HALF_HEIGHT, 32'h00020000);
    write_reg(CFG_RADIUS, 32'h00010000);
    write_reg(CFG_CENTER_X, 32'h00030000);
    random_phase(30);
    write_reg(CFG_AXIS_X, 32'h0000b505);
    write_reg(CFG_AXIS_Y, 32'h0000b505);
    write_reg(CFG_AXIS_Z, 32'h0);
    write_reg(CFG_CENTER_Y, 32'hfffe0000);
    write_reg(CFG_HALF_HEIGHT, 32'h00018000);
    write_reg(CFG_RADIUS, 32'h0000c000);
    random_phase(30);
    write_reg(CFG_AXIS_X, $urandom());
    write_reg(CFG_AXIS_Y, $urandom());
    write_reg(CFG_AXIS_Z, $urandom());
    write_reg(CFG_CENTER_Z, $urandom_range(0, 200000));
    write_reg(CFG_HALF_HEIGHT, $urandom());
    write_reg(CFG_RADIUS, $urandom());
    random_phase(14);
    write_reg(CFG_AXIS_X, 32'h0);
    write_reg(CFG_AXIS_Y, 32'h00010000);
    write_reg(CFG_AXIS_Z, 32'h0);
    write_reg(CFG_CENTER_X, 32'h0);
    write_reg(CFG_CENTER_Y, 32'h0);
    write_reg(CFG_CENTER_Z, 32'h0);
    write_reg(CFG_HALF_HEIGHT, 32'h00010000);
    write_reg(CFG_RADIUS, 32'h00008000);
    quiet = 1'b1;
    random_phase(14);
    quiet = 1'b0;
  endtask

  // more rays than the pipe holds, so the input stalls during the hold
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_req = 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 100; i++) send_ray(aimed_ray());
    quiet = 1'b0;
    wait_idle();
  endtask

  initial begin
    cyl_regs[CFG_CENTER_X] = 32'h0;
    cyl_regs[CFG_CENTER_Y] = 32'h0;
    cyl_regs[CFG_CENTER_Z] = 32'h0;
    cyl_regs[CFG_AXIS_X] = 32'h0;
    cyl_regs[CFG_AXIS_Y] = 32'h00010000;
    cyl_regs[CFG_AXIS_Z] = 32'h0;
    cyl_regs[CFG_HALF_HEIGHT] = 32'h00008000;
    cyl_regs[CFG_RADIUS] = 32'h00008000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_config_extremes();
    test_random_configs();
    test_backpressure();
    $display("sent %0d rays over several cylinder settings, checked %0d hit words", ray_cnt,
             hit_cnt);
    $display("kinds seen: miss %0d top %0d bottom %0d far %0d near %0d", kind_seen[0],
             kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (fail_cnt == 0 && hit_words_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
